>>> hdl/uvbf_pkg.sv
// uvbf_pkg: shared types, constants and helpers for the uv bounds fit/centre block
// no dependencies

package uvbf_pkg;

   localparam int unsigned AxisW  = 48;
   localparam int unsigned DataW  = 32;
   localparam int unsigned CsrIdxW = 3;
   localparam int unsigned CsrDataW = 48;
   localparam int unsigned QuotW  = 50;

   localparam logic [CsrIdxW-1:0] CSR_AXIS_U = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_AXIS_V = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_SCALE_U = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_SCALE_V = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_OFFSET_U = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_OFFSET_V = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_MODE = 3'd6;

   localparam logic signed [31:0] MaxS32 = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MinS32 = 32'sh8000_0000;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_scale_u;
      logic signed [31:0] new_scale_v;
      logic signed [31:0] new_offset_u;
      logic signed [31:0] new_offset_v;
      logic               u_adjusted;
      logic               v_adjusted;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PROD, ST_SUM, ST_BOUND, ST_DIV, ST_DONE, ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic prod;
      logic sum;
      logic bound;
      logic div_start;
      logic div_step;
      logic finish;
      logic clear;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;
      logic div_done;
   } sts_type;

   // saturate a 64-bit signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647)       r = MaxS32;
      else if (v < -64'sd2147483648) r = MinS32;
      else                           r = v[31:0];
      return r;
   endfunction

endpackage

>>> hdl/uvbf_ctrl.sv
// uvbf_ctrl: sequencing state machine for one vertex beat
// depends on uvbf_pkg

module uvbf_ctrl
   import uvbf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_BOUND;
         end
         ST_BOUND: begin
            cmd.bound = 1'b1;
            if (sts.last) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            cmd.clear  = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> hdl/uvbf_dp.sv
// uvbf_dp: projection, bounds tracking, two serial dividers (one per axis) and result formation
// depends on uvbf_pkg

module uvbf_dp
   import uvbf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  req_type             req_data,
   input  logic                csr_write,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_data,
   input  cmd_type             cmd,
   output sts_type             sts,
   output rsp_type             rsp_data
);

   logic [AxisW-1:0]   axis_u_ff, axis_v_ff;
   logic signed [31:0] scale_u_ff, scale_v_ff, offset_u_ff, offset_v_ff;
   logic               mode_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_u_ff   <= 48'h0000_4000_0000;
         axis_v_ff   <= 48'h0000_0000_4000;
         scale_u_ff  <= 32'sh0001_0000;
         scale_v_ff  <= 32'sh0001_0000;
         offset_u_ff <= '0;
         offset_v_ff <= '0;
         mode_ff     <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_AXIS_U:   axis_u_ff   <= csr_data;
            CSR_AXIS_V:   axis_v_ff   <= csr_data;
            CSR_SCALE_U:  scale_u_ff  <= csr_data[31:0];
            CSR_SCALE_V:  scale_v_ff  <= csr_data[31:0];
            CSR_OFFSET_U: offset_u_ff <= csr_data[31:0];
            CSR_OFFSET_V: offset_v_ff <= csr_data[31:0];
            CSR_MODE:     mode_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // input beat capture
   req_type in_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) in_ff <= req_data;
   end
   assign sts.last = in_ff.last_point;

   // six products, one register stage
   logic signed [47:0] pr_ff [6];
   always_ff @(posedge clock) begin
      if (cmd.prod) begin
         pr_ff[0] <= in_ff.pos_x * $signed(axis_u_ff[15:0]);
         pr_ff[1] <= in_ff.pos_y * $signed(axis_u_ff[31:16]);
         pr_ff[2] <= in_ff.pos_z * $signed(axis_u_ff[47:32]);
         pr_ff[3] <= in_ff.pos_x * $signed(axis_v_ff[15:0]);
         pr_ff[4] <= in_ff.pos_y * $signed(axis_v_ff[31:16]);
         pr_ff[5] <= in_ff.pos_z * $signed(axis_v_ff[47:32]);
      end
   end

   // sum, round half up, saturate
   logic signed [49:0] su, sv;
   logic signed [31:0] pu_ff, pv_ff;
   assign su = 50'(pr_ff[0]) + 50'(pr_ff[1]) + 50'(pr_ff[2]) + 50'sd8192;
   assign sv = 50'(pr_ff[3]) + 50'(pr_ff[4]) + 50'(pr_ff[5]) + 50'sd8192;
   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         pu_ff <= sat32(64'(su >>> 14));
         pv_ff <= sat32(64'(sv >>> 14));
      end
   end

   // running bounds
   logic signed [31:0] min_u_ff, max_u_ff, min_v_ff, max_v_ff;
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         min_u_ff <= MaxS32;
         min_v_ff <= MaxS32;
         max_u_ff <= MinS32;
         max_v_ff <= MinS32;
      end else if (cmd.bound) begin
         if (pu_ff < min_u_ff) min_u_ff <= pu_ff;
         if (pu_ff > max_u_ff) max_u_ff <= pu_ff;
         if (pv_ff < min_v_ff) min_v_ff <= pv_ff;
         if (pv_ff > max_v_ff) max_v_ff <= pv_ff;
      end
   end

   // bounds as seen with the current vertex included
   logic signed [31:0] mnu, mxu, mnv, mxv;
   assign mnu = (pu_ff < min_u_ff) ? pu_ff : min_u_ff;
   assign mxu = (pu_ff > max_u_ff) ? pu_ff : max_u_ff;
   assign mnv = (pv_ff < min_v_ff) ? pv_ff : min_v_ff;
   assign mxv = (pv_ff > max_v_ff) ? pv_ff : max_v_ff;

   // dividend and divisor per axis
   logic signed [32:0] span_u, span_v;
   logic signed [49:0] num_u, num_v;
   logic signed [33:0] den_u, den_v;
   assign span_u = 33'(mxu) - 33'(mnu);
   assign span_v = 33'(mxv) - 33'(mnv);
   always_comb begin
      if (mode_ff) begin
         num_u = (50'(mnu) + 50'(mxu)) <<< 16;
         num_v = (50'(mnv) + 50'(mxv)) <<< 16;
         den_u = 34'(scale_u_ff) <<< 1;
         den_v = 34'(scale_v_ff) <<< 1;
      end else begin
         num_u = -(50'(mnu) <<< 16);
         num_v = -(50'(mnv) <<< 16);
         den_u = 34'(span_u);
         den_v = 34'(span_v);
      end
   end

   logic adj_u_ff, adj_v_ff;
   logic [5:0] cnt_ff;
   logic       neg_u_ff, neg_v_ff;
   logic [QuotW-1:0] rem_u_ff, rem_v_ff, quo_u_ff, quo_v_ff;
   logic [33:0]      dmag_u_ff, dmag_v_ff;
   logic signed [31:0] span_sat_u_ff, span_sat_v_ff;

   // magnitudes for the restoring dividers
   logic [QuotW-1:0] nmag_u, nmag_v;
   logic [33:0]      dm_u, dm_v;
   assign nmag_u = num_u[49] ? QuotW'(-num_u) : QuotW'(num_u);
   assign nmag_v = num_v[49] ? QuotW'(-num_v) : QuotW'(num_v);
   assign dm_u   = den_u[33] ? 34'(-den_u) : 34'(den_u);
   assign dm_v   = den_v[33] ? 34'(-den_v) : 34'(den_v);

   // one quotient bit per cycle in each divider
   logic [QuotW:0] tr_u, tr_v;
   assign tr_u = {rem_u_ff, quo_u_ff[QuotW-1]};
   assign tr_v = {rem_v_ff, quo_v_ff[QuotW-1]};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         // numerator gets half the divisor added for round half away from zero
         quo_u_ff  <= nmag_u + QuotW'(dm_u >> 1);
         quo_v_ff  <= nmag_v + QuotW'(dm_v >> 1);
         rem_u_ff  <= '0;
         rem_v_ff  <= '0;
         dmag_u_ff <= dm_u;
         dmag_v_ff <= dm_v;
         neg_u_ff  <= num_u[49] ^ den_u[33];
         neg_v_ff  <= num_v[49] ^ den_v[33];
         span_sat_u_ff <= sat32(64'(span_u));
         span_sat_v_ff <= sat32(64'(span_v));
         adj_u_ff  <= mode_ff ? (scale_u_ff != 0) : (span_u > 33'sd1);
         adj_v_ff  <= mode_ff ? (scale_v_ff != 0) : (span_v > 33'sd1);
         cnt_ff    <= '0;
      end else if (cmd.div_step) begin
         if (tr_u >= (QuotW+1)'(dmag_u_ff)) begin
            rem_u_ff <= QuotW'(tr_u - (QuotW+1)'(dmag_u_ff));
            quo_u_ff <= {quo_u_ff[QuotW-2:0], 1'b1};
         end else begin
            rem_u_ff <= QuotW'(tr_u);
            quo_u_ff <= {quo_u_ff[QuotW-2:0], 1'b0};
         end
         if (tr_v >= (QuotW+1)'(dmag_v_ff)) begin
            rem_v_ff <= QuotW'(tr_v - (QuotW+1)'(dmag_v_ff));
            quo_v_ff <= {quo_v_ff[QuotW-2:0], 1'b1};
         end else begin
            rem_v_ff <= QuotW'(tr_v);
            quo_v_ff <= {quo_v_ff[QuotW-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 6'd1;
      end
   end
   assign sts.div_done = (cnt_ff == 6'(QuotW - 1));

   // signed quotients
   logic signed [63:0] q_u, q_v;
   assign q_u = neg_u_ff ? -64'(quo_u_ff) : 64'(quo_u_ff);
   assign q_v = neg_v_ff ? -64'(quo_v_ff) : 64'(quo_v_ff);

   // result register
   rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.u_adjusted <= adj_u_ff;
         rsp_ff.v_adjusted <= adj_v_ff;
         if (mode_ff) begin
            rsp_ff.new_scale_u  <= scale_u_ff;
            rsp_ff.new_scale_v  <= scale_v_ff;
            rsp_ff.new_offset_u <= adj_u_ff ? sat32(64'sd32768 - q_u) : offset_u_ff;
            rsp_ff.new_offset_v <= adj_v_ff ? sat32(64'sd32768 - q_v) : offset_v_ff;
         end else begin
            rsp_ff.new_scale_u  <= adj_u_ff ? span_sat_u_ff : scale_u_ff;
            rsp_ff.new_scale_v  <= adj_v_ff ? span_sat_v_ff : scale_v_ff;
            rsp_ff.new_offset_u <= adj_u_ff ? sat32(q_u) : offset_u_ff;
            rsp_ff.new_offset_v <= adj_v_ff ? sat32(q_v) : offset_v_ff;
         end
      end
   end
   assign rsp_data = rsp_ff;

endmodule

>>> hdl/uv_bounds_fit_center.sv
// uv_bounds_fit_center: top level, joins the controller and the datapath
// depends on uvbf_pkg, uvbf_ctrl, uvbf_dp
//
// Usage:
//   req channel carries one face vertex per beat (req_valid / req_stall);
//   last_point marks the final vertex of a face.
//   rsp channel gives one beat per face, after its last vertex, with the new
//   scale and offset of both texture axes (rsp_valid / rsp_stall).
//   csr port writes the axis, scale, offset and mode registers by index;
//   write only while the block is idle.
// Timing:
//   a vertex that is not last passes the capture, multiply, sum and bounds steps,
//   and the next vertex is not accepted until its bounds step is done.
//   a last vertex then runs the two bit-serial dividers and result forming;
//   rsp_valid rises once the result is registered, and the next
//   vertex is accepted in the cycle after the result beat is taken.
// Reset:
//   synchronous; configuration registers take their reset values and bounds are empty.
// Stall:
//   the result is held in its register while rsp_stall is high and no new
//   vertex is accepted until it has been taken.

module uv_bounds_fit_center
   import uvbf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_write,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   // sequencer
   uvbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic
   uvbf_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

>>> test/uvbf_checker.sv
// uvbf_checker: watches the vertex and result channels of uv_bounds_fit_center,
// predicts each face result and compares it field by field
// depends on uvbf_pkg

module uvbf_checker
   import uvbf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  req_type             req_data,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  rsp_type             rsp_data,
   input  logic                csr_write,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_data,
   output int                  fail_count,
   output int                  pending_faces
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow registers
   logic [47:0] axis_u, axis_v;
   logic [31:0] scale_u, scale_v, offset_u, offset_v;
   logic        centre_mode;
   // running bounds of the current face
   longint lo_u, lo_v, hi_u, hi_v;
   rsp_type face_results[$];

   function automatic longint to_s32(logic [31:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // division rounded half away from zero
   function automatic longint div_round(longint n, longint d);
      logic   neg;
      longint un, ud, q;
      neg = (n < 0) != (d < 0);
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      q = (un + ud / 2) / ud;
      return neg ? -q : q;
   endfunction

   // dot product with a Q2.14 axis, rounded half up, saturated
   function automatic longint project_axis(req_type p, logic [47:0] ax);
      longint s;
      s = to_s32(p.pos_x) * longint'($signed(ax[15:0]))
        + to_s32(p.pos_y) * longint'($signed(ax[31:16]))
        + to_s32(p.pos_z) * longint'($signed(ax[47:32])) + 8192;
      s = s >>> 14;
      return clamp32(s);
   endfunction

   task automatic clear_bounds();
      lo_u = 64'sd2147483647;  lo_v = 64'sd2147483647;
      hi_u = -64'sd2147483648; hi_v = -64'sd2147483648;
   endtask

   task automatic absorb_vertex(req_type p);
      longint     u, v, su, sv, ou, ov;
      logic       au, av;
      rsp_type    r;
      u = project_axis(p, axis_u);
      v = project_axis(p, axis_v);
      if (u < lo_u) lo_u = u;
      if (u > hi_u) hi_u = u;
      if (v < lo_v) lo_v = v;
      if (v > hi_v) hi_v = v;
      if (!p.last_point) return;
      su = to_s32(scale_u); sv = to_s32(scale_v);
      ou = to_s32(offset_u); ov = to_s32(offset_v);
      au = 0; av = 0;
      if (centre_mode) begin
         if (su != 0) begin
            ou = clamp32(32768 - div_round((lo_u + hi_u) * 65536, 2 * su)); au = 1;
         end
         if (sv != 0) begin
            ov = clamp32(32768 - div_round((lo_v + hi_v) * 65536, 2 * sv)); av = 1;
         end
      end else begin
         if (hi_u - lo_u > 1) begin
            ou = clamp32(div_round(-lo_u * 65536, hi_u - lo_u));
            su = clamp32(hi_u - lo_u); au = 1;
         end
         if (hi_v - lo_v > 1) begin
            ov = clamp32(div_round(-lo_v * 65536, hi_v - lo_v));
            sv = clamp32(hi_v - lo_v); av = 1;
         end
      end
      r.new_scale_u = su[31:0];  r.new_scale_v = sv[31:0];
      r.new_offset_u = ou[31:0]; r.new_offset_v = ov[31:0];
      r.u_adjusted = au;         r.v_adjusted = av;
      face_results.push_back(r);
      clear_bounds();
   endtask

   // sample every channel at the clock edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         axis_u <= 48'h0000_4000_0000; axis_v <= 48'h0000_0000_4000;
         scale_u <= 32'h0001_0000; scale_v <= 32'h0001_0000;
         offset_u <= '0; offset_v <= '0; centre_mode <= 1'b0;
         clear_bounds();
         face_results.delete();
         fail_count <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_AXIS_U:   axis_u <= csr_data;
               CSR_AXIS_V:   axis_v <= csr_data;
               CSR_SCALE_U:  scale_u <= csr_data[31:0];
               CSR_SCALE_V:  scale_v <= csr_data[31:0];
               CSR_OFFSET_U: offset_u <= csr_data[31:0];
               CSR_OFFSET_V: offset_v <= csr_data[31:0];
               CSR_MODE:     centre_mode <= csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) absorb_vertex(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (face_results.size() == 0) begin
               if (fail_count < 10) $display("unexpected result beat %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = face_results.pop_front();
               if (rsp_data !== want) begin
                  if (fail_count < 10) $display("mismatch exp %p got %p", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

   assign pending_faces = face_results.size();

endmodule

>>> test/testbench.sv
// testbench: stimulus and verdict for uv_bounds_fit_center
// depends on uvbf_pkg, uv_bounds_fit_center and uvbf_checker

module testbench;
   import uvbf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_write = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_data = '0;
   int                  fail_count;
   int                  pending_faces;
   int                  cycle_count = 0;
   int                  stall_left = 0;
   logic                stim_done = 1'b0;

   uv_bounds_fit_center i_dut (.*);

   uvbf_checker i_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // random gap length, mostly short
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom();
         default: return $unsigned($signed(32'($urandom_range(0, 2000 << 16)))
                                   - 32'sd1000 * 65536);
      endcase
   endfunction

   function automatic logic [47:0] rand_axis();
      logic [47:0] a;
      a = 48'({$urandom(), $urandom()});
      if ($urandom_range(0, 2) == 0) a = '0;
      else if ($urandom_range(0, 1)) begin
         a = '0;
         a[16 * $urandom_range(0, 2) +: 16] = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
      end
      return a;
   endfunction

   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] val);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // block idle: no face pending, then let any partial vertex drain
   task automatic wait_idle();
      while (pending_faces != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
      repeat (gap_len()) @(posedge clock);
      req_valid <= 1'b1;
      req_data <= '{pos_x: x, pos_y: y, pos_z: z, last_point: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_face(int n);
      for (int i = 0; i < n; i++)
         send_vertex(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
   endtask

   task automatic random_regs(logic mode);
      write_reg(CSR_AXIS_U, rand_axis());
      write_reg(CSR_AXIS_V, rand_axis());
      write_reg(CSR_SCALE_U, $urandom_range(0, 3) == 0 ? 48'h0
                                                       : 48'({$urandom(), $urandom()}));
      write_reg(CSR_SCALE_V, $urandom_range(0, 1) ? 48'h1_0000
                                                  : 48'({$urandom(), $urandom()}));
      write_reg(CSR_OFFSET_U, 48'({$urandom(), $urandom()}));
      write_reg(CSR_OFFSET_V, 48'({$urandom(), $urandom()}));
      write_reg(CSR_MODE, {47'h0, mode});
   endtask

   // receiver stalls, runs of random length
   always @(posedge clock) begin
      if (stim_done) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) < 3) begin
         rsp_stall  <= 1'b1;
         stall_left <= gap_len();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      int sent;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset registers, a single vertex face, two vertex faces and extremes
      send_vertex(32'h0, 32'h0, 32'h0, 1'b1);
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
      send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0, 1'b0);
      send_vertex(32'h0001_0001, 32'h0002_0000, 32'h0, 1'b1);
      send_vertex(32'h0003_0000, 32'hFFFF_0000, 32'h0, 1'b0);
      send_vertex(32'hFFFD_0000, 32'h0005_0000, 32'hFFFF_FFFF, 1'b1);
      wait_idle();
      // centre mode with zero and extreme scales
      write_reg(CSR_MODE, 48'h1);
      write_reg(CSR_SCALE_U, 48'h0);
      write_reg(CSR_SCALE_V, 48'hFFFF_8000_0000);
      write_reg(CSR_OFFSET_U, 48'h7FFF_FFFF);
      write_reg(CSR_OFFSET_V, 48'h8000_0000);
      write_reg(CSR_AXIS_U, 48'h8000_8000_8000);
      write_reg(CSR_AXIS_V, 48'h7FFF_7FFF_7FFF);
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_vertex(32'h1234_5678, 32'h8765_4321, 32'h0, 1'b1);
      wait_idle();
      write_reg(CSR_SCALE_U, 48'h1);
      send_vertex(32'h0000_0001, 32'h0, 32'h0, 1'b1);
      wait_idle();
      write_reg(CSR_MODE, 48'h0);
      send_vertex(32'h8000_0000, 32'h0, 32'h0, 1'b0);
      send_vertex(32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1);
      wait_idle();

      // random phases with fresh register settings
      sent = 0;
      while (sent < 1150) begin
         random_regs($urandom_range(0, 1));
         for (int f = 0; f < 12; f++) begin
            int n;
            n = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
            random_face(n);
            sent += n;
         end
         wait_idle();
      end

      stim_done <= 1'b1;
      while (pending_faces != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

endmodule

>>> files.f
hdl/uvbf_pkg.sv
hdl/uvbf_ctrl.sv
hdl/uvbf_dp.sv
hdl/uv_bounds_fit_center.sv
test/uvbf_checker.sv
test/testbench.sv
